>>> src/ssve_pkg.sv
// shared types and constants for the streak sprite clip and vertex emit block
package ssve_pkg;

    localparam int COORD_W             = 20;
    localparam int DEPTH_W             = 17;
    localparam int Z_W                 = 16;
    localparam int BOUND_W             = 16;
    localparam int CFG_IDX_W           = 3;
    localparam int COORD_FRAC_BITS_DEF = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_FADE      = 3'd4;

    typedef struct packed {
        logic signed [BOUND_W-1:0] view_left;
        logic signed [BOUND_W-1:0] view_right;
        logic signed [BOUND_W-1:0] view_top;
        logic signed [BOUND_W-1:0] view_bottom;
        logic        [Z_W-1:0]     z_fade_scale;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] head_x;
        logic signed [COORD_W-1:0] head_y;
        logic signed [COORD_W-1:0] tail_x;
        logic signed [COORD_W-1:0] tail_y;
        logic        [DEPTH_W-1:0] depth;
        logic                      last_flake;
    } t_flake;

    typedef struct packed {
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] head_x;
        logic signed [COORD_W-1:0] head_y;
        logic signed [COORD_W-1:0] tail_x;
        logic signed [COORD_W-1:0] tail_y;
        logic        [Z_W-1:0]     z;
        logic                      last_flake;
    } t_particle;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_MID,
        EMIT_TAIL,
        EMIT_HEAD
    } t_emit_state;

endpackage

>>> src/ssve_cfg.sv
// configuration register file of the streak sprite block
module ssve_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ssve_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssve_pkg::BOUND_W-1:0]       i_cfg_wdata,
    output ssve_pkg::t_cfg                     o_cfg
);

    ssve_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_left    <= 16'sd0;
            r_cfg.view_right   <= 16'sd640;
            r_cfg.view_top     <= 16'sd0;
            r_cfg.view_bottom  <= 16'sd480;
            r_cfg.z_fade_scale <= 16'd1638;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssve_pkg::CFG_VIEW_LEFT:   r_cfg.view_left    <= i_cfg_wdata;
                ssve_pkg::CFG_VIEW_RIGHT:  r_cfg.view_right   <= i_cfg_wdata;
                ssve_pkg::CFG_VIEW_TOP:    r_cfg.view_top     <= i_cfg_wdata;
                ssve_pkg::CFG_VIEW_BOTTOM: r_cfg.view_bottom  <= i_cfg_wdata;
                ssve_pkg::CFG_Z_FADE:      r_cfg.z_fade_scale <= i_cfg_wdata;
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/ssve_calc.sv
// three-stage clip, midpoint and depth pipeline
module ssve_calc #(
    parameter int COORD_FRAC_BITS = ssve_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssve_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  ssve_pkg::t_flake    i_flake,
    output logic                o_valid,
    input  logic                i_ready,
    output ssve_pkg::t_particle o_particle
);

    localparam int SCL_W = ssve_pkg::BOUND_W + COORD_FRAC_BITS;
    localparam int CMP_W = ((SCL_W > ssve_pkg::COORD_W) ? SCL_W : ssve_pkg::COORD_W) + 1;
    localparam int CW    = ssve_pkg::COORD_W;
    localparam int DW    = ssve_pkg::DEPTH_W;
    localparam int PW    = 2 * ssve_pkg::Z_W;

    // stage 1: input beat
    logic             r1_v;
    ssve_pkg::t_flake r1_f;
    // stage 2: clip result, midpoint, one minus depth
    logic             r2_v;
    logic             r2_kept;
    logic             r2_zero;
    logic [DW-1:0]    r2_diff;
    logic signed [CW-1:0] r2_mid;
    ssve_pkg::t_flake r2_f;
    // stage 3: finished particle
    logic                r3_v;
    ssve_pkg::t_particle r3_p;

    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [CMP_W-1:0] w_left, w_right, w_top, w_bottom;
    logic signed [CMP_W-1:0] w_hx, w_hy, w_tx, w_ty;
    logic                    w_kept;
    logic signed [CW:0]      w_sum;
    logic [DW-1:0]           w_diff;
    logic [PW-1:0]           w_prod;

    assign w_rdy3  = !r3_v || i_ready;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;

    // bounds in whole pixels scaled into coordinate fixed point
    assign w_left   = CMP_W'(i_cfg.view_left)   <<< COORD_FRAC_BITS;
    assign w_right  = CMP_W'(i_cfg.view_right)  <<< COORD_FRAC_BITS;
    assign w_top    = CMP_W'(i_cfg.view_top)    <<< COORD_FRAC_BITS;
    assign w_bottom = CMP_W'(i_cfg.view_bottom) <<< COORD_FRAC_BITS;
    assign w_hx = CMP_W'(r1_f.head_x);
    assign w_hy = CMP_W'(r1_f.head_y);
    assign w_tx = CMP_W'(r1_f.tail_x);
    assign w_ty = CMP_W'(r1_f.tail_y);

    assign w_kept = (w_left <= w_hx) && (w_tx < w_right) &&
                    (w_top <= w_hy) && (w_ty < w_bottom);

    // floor of the half sum is the upper bits of the two's complement sum
    assign w_sum = (CW+1)'(r1_f.head_x) + (CW+1)'(r1_f.tail_x);

    // 1 - depth, only meaningful below one; one and above give a z of zero
    assign w_diff = DW'(18'h10000 - {2'b00, r1_f.depth[DW-2:0]});
    // fade product is formed in the third stage
    assign w_prod = PW'(r2_diff) * PW'(i_cfg.z_fade_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_v <= i_valid;
            end
            if (w_rdy2) begin
                r2_v <= r1_v;
            end
            if (w_rdy3) begin
                r3_v <= r2_v && r2_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_f <= i_flake;
        end
        if (w_rdy2) begin
            r2_f    <= r1_f;
            r2_kept <= w_kept;
            r2_zero <= r1_f.depth[DW-1];
            r2_diff <= w_diff;
            r2_mid  <= w_sum[CW:1];
        end
        if (w_rdy3) begin
            r3_p.mid_x      <= r2_mid;
            r3_p.head_x     <= r2_f.head_x;
            r3_p.head_y     <= r2_f.head_y;
            r3_p.tail_x     <= r2_f.tail_x;
            r3_p.tail_y     <= r2_f.tail_y;
            r3_p.z          <= r2_zero ? '0 : w_prod[PW-1:ssve_pkg::Z_W];
            r3_p.last_flake <= r2_f.last_flake;
        end
    end

    assign o_valid    = r3_v;
    assign o_particle = r3_p;

endmodule

>>> src/ssve_emit.sv
// vertex sequencer: three beats per kept particle
module ssve_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ssve_pkg::t_particle         i_particle,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ssve_pkg::COORD_W-1:0] o_vert_x,
    output logic [ssve_pkg::COORD_W-1:0] o_vert_y,
    output logic [ssve_pkg::Z_W-1:0]    o_vert_z,
    output logic [1:0]                  o_tex_u,
    output logic                        o_tex_v,
    output logic                        o_corner_last,
    output logic                        o_batch_end
);

    localparam logic [1:0] TEX_U_ZERO = 2'd0;
    localparam logic [1:0] TEX_U_HALF = 2'd1;
    localparam logic [1:0] TEX_U_ONE  = 2'd2;

    ssve_pkg::t_emit_state r_state, n_state;
    ssve_pkg::t_particle   r_p;
    logic                  w_load;

    assign o_ready = (r_state == ssve_pkg::EMIT_IDLE) ||
                     (r_state == ssve_pkg::EMIT_HEAD && i_ready);
    assign w_load  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssve_pkg::EMIT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_p <= i_particle;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_valid       = 1'b1;
        o_vert_x      = r_p.head_x;
        o_vert_y      = r_p.tail_y;
        o_tex_u       = TEX_U_ZERO;
        o_tex_v       = 1'b1;
        o_corner_last = 1'b0;
        case (r_state)
            ssve_pkg::EMIT_IDLE: begin
                o_valid = 1'b0;
                if (i_valid) begin
                    n_state = ssve_pkg::EMIT_MID;
                end
            end
            ssve_pkg::EMIT_MID: begin
                o_vert_x = r_p.mid_x;
                o_vert_y = r_p.head_y;
                o_tex_u  = TEX_U_HALF;
                o_tex_v  = 1'b0;
                if (i_ready) begin
                    n_state = ssve_pkg::EMIT_TAIL;
                end
            end
            ssve_pkg::EMIT_TAIL: begin
                o_vert_x = r_p.tail_x;
                o_tex_u  = TEX_U_ONE;
                if (i_ready) begin
                    n_state = ssve_pkg::EMIT_HEAD;
                end
            end
            ssve_pkg::EMIT_HEAD: begin
                o_corner_last = 1'b1;
                if (i_ready) begin
                    n_state = i_valid ? ssve_pkg::EMIT_MID : ssve_pkg::EMIT_IDLE;
                end
            end
            default: begin
                o_valid = 1'b0;
                n_state = ssve_pkg::EMIT_IDLE;
            end
        endcase
    end

    assign o_vert_z    = r_p.z;
    assign o_batch_end = r_p.last_flake;

    // a stalled vertex keeps its corner
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_state == $past(r_state)))
        else $error("corner changed under stall");

    // the tail corner only follows the midpoint corner
    a_tail_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssve_pkg::EMIT_MID && i_ready) |=> (r_state == ssve_pkg::EMIT_TAIL))
        else $error("tail corner out of order");

    // the head corner only follows the tail corner
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssve_pkg::EMIT_TAIL && i_ready) |=> (r_state == ssve_pkg::EMIT_HEAD))
        else $error("head corner out of order");

    // a new particle is never taken in the middle of a triangle
    a_load_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_state == ssve_pkg::EMIT_IDLE || r_state == ssve_pkg::EMIT_HEAD))
        else $error("particle loaded mid-triangle");

endmodule

>>> src/streak_sprite_clip_vertex_emit.sv
// top level of the streak sprite clip and vertex emit block
//
// usage:
//   slave stream: one beat per particle (head and tail points, depth), tlast
//   marks the final particle of a batch. master stream: one beat per
//   triangle vertex, three beats per particle that lies inside the viewport,
//   tlast on the third vertex, tuser copies the batch end flag onto all three.
//   a particle outside the viewport is dropped and gives no beat at all.
// path: an accepted particle passes the input, clip/midpoint and depth
//   multiply stages, then the vertex sequencer register, before its first
//   vertex shows on the master side.
// throughput: three vertex beats per kept particle, set by the single vertex
//   port of the sequencer; dropped particles pass at one per cycle unless a stall holds them.
// configuration: plain write port, index 0..4 = left, right, top, bottom,
//   fade scale; write only while no particle is in flight.
// reset: synchronous, clears all valid bits and the sequencer, and loads
//   the viewport 0..640 by 0..480 and a fade scale of 1638.
// stall: while tready is low the current vertex holds, the pipeline fills
//   behind it and tready on the slave side drops once every stage is full.
module streak_sprite_clip_vertex_emit #(
    parameter int COORD_FRAC_BITS = ssve_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [ssve_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssve_pkg::BOUND_W-1:0]       i_cfg_wdata,
    // particle beats
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // head_x[19:0], head_y[39:20], tail_x[59:40], tail_y[79:60],
    // depth[96:80], zero fill[103:97]
    input  logic [103:0]                       s_axis_tdata,
    input  logic                               s_axis_tlast,
    // vertex beats
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // vert_x[19:0], vert_y[39:20], vert_z[55:40], tex_u[57:56], tex_v[58],
    // zero fill[63:59]
    output logic [63:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    // batch_end
    output logic                               m_axis_tuser
);

    localparam int CW = ssve_pkg::COORD_W;

    ssve_pkg::t_cfg      w_cfg;
    ssve_pkg::t_flake    w_flake;
    ssve_pkg::t_particle w_part;
    logic                w_part_valid;
    logic                w_part_ready;

    logic [CW-1:0]              w_vert_x;
    logic [CW-1:0]              w_vert_y;
    logic [ssve_pkg::Z_W-1:0]   w_vert_z;
    logic [1:0]                 w_tex_u;
    logic                       w_tex_v;

    // unpack the particle beat
    assign w_flake.head_x     = s_axis_tdata[CW-1:0];
    assign w_flake.head_y     = s_axis_tdata[2*CW-1:CW];
    assign w_flake.tail_x     = s_axis_tdata[3*CW-1:2*CW];
    assign w_flake.tail_y     = s_axis_tdata[4*CW-1:3*CW];
    assign w_flake.depth      = s_axis_tdata[4*CW+ssve_pkg::DEPTH_W-1:4*CW];
    assign w_flake.last_flake = s_axis_tlast;

    ssve_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // clip test, midpoint and depth fade
    ssve_calc #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_flake    (w_flake),
        .o_valid    (w_part_valid),
        .i_ready    (w_part_ready),
        .o_particle (w_part)
    );

    // three vertices per particle
    ssve_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_part_valid),
        .o_ready       (w_part_ready),
        .i_particle    (w_part),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_vert_x      (w_vert_x),
        .o_vert_y      (w_vert_y),
        .o_vert_z      (w_vert_z),
        .o_tex_u       (w_tex_u),
        .o_tex_v       (w_tex_v),
        .o_corner_last (m_axis_tlast),
        .o_batch_end   (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b00000, w_tex_v, w_tex_u, w_vert_z, w_vert_y, w_vert_x};

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the streak sprite clip and vertex emit block
module tb_top;

    localparam int       COORD_W      = ssve_pkg::COORD_W;
    localparam int       DEPTH_W      = ssve_pkg::DEPTH_W;
    localparam int       Z_W          = ssve_pkg::Z_W;
    localparam int       BOUND_W      = ssve_pkg::BOUND_W;
    localparam int       CFG_IDX_W    = ssve_pkg::CFG_IDX_W;
    // screen coordinates carry this many fraction bits, bounds are whole pixels
    localparam int       FRAC         = ssve_pkg::COORD_FRAC_BITS_DEF;
    localparam longint   PIX_SCALE    = longint'(1) << FRAC;
    localparam longint   ONE_Q16      = 65536;
    localparam longint   COORD_MIN    = -(longint'(1) << (COORD_W - 1));
    localparam longint   COORD_MAX    = (longint'(1) << (COORD_W - 1)) - 1;
    localparam int       LAST_IDX     = (1 << CFG_IDX_W) - 1;
    localparam int       DRAIN_SETTLE = 12;      // covers the pipeline depth of dropped beats
    localparam int       HOLD_CYCLES  = 90;      // long receiver back-pressure stretch
    localparam int       CYCLE_LIMIT  = 300000;
    localparam int       SHOW_ERRORS  = 10;

    // tex_u in halves of the texture
    localparam logic [1:0] TEX_U_ZERO = 2'd0;
    localparam logic [1:0] TEX_U_HALF = 2'd1;
    localparam logic [1:0] TEX_U_ONE  = 2'd2;

    // one triangle vertex as it leaves the master side
    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic        [Z_W-1:0]     vz;
        logic        [1:0]         tu;
        logic                      tv;
        logic                      corner;
        logic                      bend;
    } t_vertex;

    // keeps a copy of the viewport registers, predicts the vertices of each
    // accepted particle and checks the vertex beats against them in order
    class tri_vertex_board;
        ssve_pkg::t_cfg cfg;
        t_vertex        due_vertices[$];
        int             n_err;

        function new();
            cfg.view_left    = 16'sd0;
            cfg.view_right   = 16'sd640;
            cfg.view_top     = 16'sd0;
            cfg.view_bottom  = 16'sd480;
            cfg.z_fade_scale = 16'd1638;
            n_err            = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BOUND_W-1:0] d);
            case (idx)
                ssve_pkg::CFG_VIEW_LEFT:   cfg.view_left    = d;
                ssve_pkg::CFG_VIEW_RIGHT:  cfg.view_right   = d;
                ssve_pkg::CFG_VIEW_TOP:    cfg.view_top     = d;
                ssve_pkg::CFG_VIEW_BOTTOM: cfg.view_bottom  = d;
                ssve_pkg::CFG_Z_FADE:      cfg.z_fade_scale = d;
                default: ;   // spare indexes write nothing
            endcase
        endfunction

        function void note_particle(ssve_pkg::t_flake f);
            longint          hx, hy, tx, ty, mid, zp;
            logic [Z_W-1:0]  z;
            t_vertex         v;
            hx = f.head_x;
            hy = f.head_y;
            tx = f.tail_x;
            ty = f.tail_y;
            // head must be at or past left/top, tail strictly before right/bottom
            if (!(hx >= longint'(cfg.view_left) * PIX_SCALE &&
                  tx <  longint'(cfg.view_right) * PIX_SCALE &&
                  hy >= longint'(cfg.view_top) * PIX_SCALE &&
                  ty <  longint'(cfg.view_bottom) * PIX_SCALE))
                return;
            // arithmetic shift halves toward minus infinity
            mid = (hx + tx) >>> 1;
            // (1 - depth) * fade, depth above one goes negative and clamps to zero
            zp = (ONE_Q16 - longint'(f.depth)) * longint'(cfg.z_fade_scale);
            if (zp < 0)
                z = '0;
            else if ((zp >>> 16) > longint'({Z_W{1'b1}}))
                z = '1;
            else
                z = zp[Z_W+15:16];
            v = '{vx: mid[COORD_W-1:0], vy: hy[COORD_W-1:0], vz: z, tu: TEX_U_HALF,
                  tv: 1'b0, corner: 1'b0, bend: f.last_flake};
            due_vertices = {due_vertices, v};
            v = '{vx: tx[COORD_W-1:0], vy: ty[COORD_W-1:0], vz: z, tu: TEX_U_ONE,
                  tv: 1'b1, corner: 1'b0, bend: f.last_flake};
            due_vertices = {due_vertices, v};
            v = '{vx: hx[COORD_W-1:0], vy: ty[COORD_W-1:0], vz: z, tu: TEX_U_ZERO,
                  tv: 1'b1, corner: 1'b1, bend: f.last_flake};
            due_vertices = {due_vertices, v};
        endfunction

        function void check_vertex(t_vertex got);
            t_vertex want;
            if (due_vertices.size() == 0) begin
                if (n_err < SHOW_ERRORS)
                    $display("vertex beat with none pending: x=%0d y=%0d z=%0d u=%0d v=%0d",
                             got.vx, got.vy, got.vz, got.tu, got.tv);
                n_err++;
                return;
            end
            want = due_vertices.pop_front();
            if (want.vx != got.vx || want.vy != got.vy || want.vz != got.vz ||
                want.tu != got.tu || want.tv != got.tv || want.corner != got.corner ||
                want.bend != got.bend) begin
                if (n_err < SHOW_ERRORS) begin
                    $display({"vertex mismatch, expected x=%0d y=%0d z=%0d u=%0d v=%0d",
                              " last=%0b end=%0b"},
                             want.vx, want.vy, want.vz, want.tu, want.tv, want.corner,
                             want.bend);
                    $display({"                 actual   x=%0d y=%0d z=%0d u=%0d v=%0d",
                              " last=%0b end=%0b"},
                             got.vx, got.vy, got.vz, got.tu, got.tv, got.corner, got.bend);
                end
                n_err++;
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [BOUND_W-1:0]   i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [103:0]         s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    tri_vertex_board board = new();

    // idle percentages per side, and a request for a long receiver hold-off
    int snd_idle = 0;
    int rcv_idle = 0;
    bit hold_req = 1'b0;
    int cycles   = 0;

    always #6 i_clk = ~i_clk;

    streak_sprite_clip_vertex_emit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // watchdog, far above the slowest legal run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // vertex side: check the beat taken at this edge, then pick tready for the next one
    initial begin
        int      hold_cnt;
        t_vertex got;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = '{vx: m_axis_tdata[19:0], vy: m_axis_tdata[39:20],
                        vz: m_axis_tdata[55:40], tu: m_axis_tdata[57:56],
                        tv: m_axis_tdata[58], corner: m_axis_tlast, bend: m_axis_tuser};
                board.check_vertex(got);
            end
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99, 0) >= rcv_idle);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v < COORD_MIN)
            return COORD_MIN[COORD_W-1:0];
        if (v > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic ssve_pkg::t_flake mk_flake(longint hx, longint hy, longint tx,
                                                  longint ty, longint depth, bit last);
        ssve_pkg::t_flake f;
        f.head_x     = hx[COORD_W-1:0];
        f.head_y     = hy[COORD_W-1:0];
        f.tail_x     = tx[COORD_W-1:0];
        f.tail_y     = ty[COORD_W-1:0];
        f.depth      = depth[DEPTH_W-1:0];
        f.last_flake = last;
        return f;
    endfunction

    // a particle that lands inside the current viewport, or a fully random one
    function automatic ssve_pkg::t_flake gen_flake(bit keep_it);
        ssve_pkg::t_flake f;
        longint lo_x, hi_x, lo_y, hi_y;
        lo_x = longint'(board.cfg.view_left) * PIX_SCALE;
        hi_x = longint'(board.cfg.view_right) * PIX_SCALE;
        lo_y = longint'(board.cfg.view_top) * PIX_SCALE;
        hi_y = longint'(board.cfg.view_bottom) * PIX_SCALE;
        if (keep_it) begin
            f.head_x = clamp_coord(lo_x + longint'($urandom_range(4095, 0)));
            f.tail_x = clamp_coord(hi_x - 1 - longint'($urandom_range(4095, 0)));
            f.head_y = clamp_coord(lo_y + longint'($urandom_range(4095, 0)));
            f.tail_y = clamp_coord(hi_y - 1 - longint'($urandom_range(4095, 0)));
        end else begin
            f.head_x = COORD_W'($urandom);
            f.head_y = COORD_W'($urandom);
            f.tail_x = COORD_W'($urandom);
            f.tail_y = COORD_W'($urandom);
        end
        // mostly depths in 0..1.0, sometimes the whole field
        if ($urandom_range(9, 0) == 0)
            f.depth = DEPTH_W'($urandom);
        else
            f.depth = DEPTH_W'($urandom_range(65536, 0));
        f.last_flake = ($urandom_range(7, 0) == 0);
        return f;
    endfunction

    // offer one particle beat, with random idle cycles ahead of it
    task automatic push_particle(input ssve_pkg::t_flake f);
        while ($urandom_range(99, 0) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, f.depth, f.tail_y, f.tail_x, f.head_y, f.head_x};
        s_axis_tlast  <= f.last_flake;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        board.note_particle(f);
    endtask

    // stop offering and wait until every predicted vertex has come back,
    // then let dropped beats still in the pipeline run out
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (board.due_vertices.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // write all five registers back to back, block is idle
    task automatic set_view(logic [BOUND_W-1:0] l, logic [BOUND_W-1:0] r,
                            logic [BOUND_W-1:0] t, logic [BOUND_W-1:0] b,
                            logic [BOUND_W-1:0] fade);
        logic [BOUND_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0] idxs[5];
        vals = '{l, r, t, b, fade};
        idxs = '{ssve_pkg::CFG_VIEW_LEFT, ssve_pkg::CFG_VIEW_RIGHT, ssve_pkg::CFG_VIEW_TOP,
                 ssve_pkg::CFG_VIEW_BOTTOM, ssve_pkg::CFG_Z_FADE};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            board.set_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // main sequence
    initial begin
        ssve_pkg::t_flake dir_a[$];
        ssve_pkg::t_flake dir_b[$];
        logic [BOUND_W-1:0] junk;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset viewport 0..640 x 0..480 and default fade
        dir_a = {dir_a, mk_flake(0, 0, 10239, 7679, 0, 0)};          // every bound just met
        dir_a = {dir_a, mk_flake(-1, 0, 100, 100, 30000, 0)};        // head left of view
        dir_a = {dir_a, mk_flake(0, 0, 10240, 100, 30000, 0)};       // tail on right bound
        dir_a = {dir_a, mk_flake(0, -1, 100, 100, 30000, 0)};        // head above view
        dir_a = {dir_a, mk_flake(0, 0, 100, 7680, 30000, 0)};        // tail on bottom bound
        dir_a = {dir_a, mk_flake(0, 16, -3, 20, 65536, 0)};          // odd negative sum, depth one
        dir_a = {dir_a, mk_flake(100, 100, 200, 200, 65537, 1)};     // depth past one, batch end
        dir_a = {dir_a, mk_flake(-16, 5, 5, 5, 1000, 1)};            // clipped batch end
        dir_a = {dir_a, mk_flake(1, 1, 1, 1, 131071, 0)};            // depth field all ones
        foreach (dir_a[k])
            push_particle(dir_a[k]);
        drain_block();

        // widest viewport, full fade, then writes to spare indexes that must change nothing
        set_view(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
        for (int k = ssve_pkg::CFG_Z_FADE + 1; k <= LAST_IDX; k++) begin
            junk = BOUND_W'($urandom);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= k[CFG_IDX_W-1:0];
            i_cfg_wdata <= junk;
            @(posedge i_clk);
            board.set_reg(k[CFG_IDX_W-1:0], junk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);

        dir_b = {dir_b, mk_flake(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0)};
        dir_b = {dir_b, mk_flake(COORD_MAX, COORD_MAX, 524271, 524271, 1, 1)};
        dir_b = {dir_b, mk_flake(COORD_MAX, COORD_MAX, 524272, 0, 2, 0)}; // tail on right bound
        dir_b = {dir_b, mk_flake(-1, -1, -2, -2, 32768, 0)};
        dir_b = {dir_b, mk_flake('h55555, 'haaaaa, 'haaaaa, 'h55555, 'h0aaaa, 0)};
        dir_b = {dir_b, mk_flake('haaaaa, 'h55555, 'h55555, 'h2aaaa, 'h15555, 1)};
        foreach (dir_b[k])
            push_particle(dir_b[k]);
        drain_block();

        // random part: three idle patterns, two register settings each
        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin snd_idle = 36; rcv_idle = 59; end
                1: begin snd_idle = 59; rcv_idle = 36; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            case (p)
                0: set_view(16'd0, 16'd640, 16'd0, 16'd480, 16'd1638);
                1: set_view(-BOUND_W'($urandom_range(2000, 0)),
                            BOUND_W'($urandom_range(2000, 1)),
                            -BOUND_W'($urandom_range(2000, 0)),
                            BOUND_W'($urandom_range(2000, 1)),
                            BOUND_W'($urandom));
                2: set_view(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
                3: set_view(BOUND_W'($urandom), BOUND_W'($urandom), BOUND_W'($urandom),
                            BOUND_W'($urandom), BOUND_W'($urandom));
                4: set_view(16'd100, 16'd101, -16'sd5, -16'sd4, 16'hffff);
                default: set_view(-BOUND_W'($urandom_range(300, 0)),
                                  BOUND_W'($urandom_range(900, 1)),
                                  -BOUND_W'($urandom_range(300, 0)),
                                  BOUND_W'($urandom_range(900, 1)),
                                  BOUND_W'($urandom));
            endcase
            for (int k = 0; k < 45; k++) begin
                if (p == 4 && k == 15) begin
                    // receiver holds off while particles keep coming, input must back up
                    hold_req = 1'b1;
                    repeat (12) push_particle(gen_flake(1'b1));
                end
                if (p == 4 && k == 30)
                    drain_block();   // sender pauses until every vertex is out
                push_particle(gen_flake($urandom_range(3, 0) != 0));
            end
            drain_block();
        end

        if (board.n_err == 0 && board.due_vertices.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
src/ssve_pkg.sv
src/ssve_cfg.sv
src/ssve_calc.sv
src/ssve_emit.sv
src/streak_sprite_clip_vertex_emit.sv
tb/tb_top.sv
